// File: src/mbe_pkg.sv
// Shared constants, types and lookup tables for the escape-time pixel engine.
// No dependencies; the interfaces and the pixel engine refer to it by scoped names.
package mbe_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int FRAC_BITS  = 58;
    localparam int ITER_BITS  = 16;

    // log2 result: integer part up to 127 - 2*FRAC_BITS, 16 fraction bits
    localparam int LG_W = 23;

    localparam logic [15:0] SMOOTH_K = 16'd55307;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_START  = 3'd0,
        CFG_X_STEP   = 3'd1,
        CFG_Y_START  = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_MAX_ITER = 3'd4
    } t_cfg_idx;

    // phase increment per unit of smooth value, Q0.32 of a turn
    function automatic logic [23:0] turn_k(input logic [1:0] ch);
        logic [23:0] k;
        case (ch)
            2'd0:    k = 24'd12987740;
            2'd1:    k = 24'd11620610;
            default: k = 24'd10253479;
        endcase
        return k;
    endfunction

    // log2(1 + k/16) in Q1.16
    function automatic logic [16:0] log_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // sin(k*pi/32) in Q1.16, quarter wave
    function automatic logic [16:0] sine_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6424;
            5'd2:    v = 17'd12785;
            5'd3:    v = 17'd19024;
            5'd4:    v = 17'd25080;
            5'd5:    v = 17'd30893;
            5'd6:    v = 17'd36410;
            5'd7:    v = 17'd41576;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd50660;
            5'd10:   v = 17'd54491;
            5'd11:   v = 17'd57798;
            5'd12:   v = 17'd60547;
            5'd13:   v = 17'd62714;
            5'd14:   v = 17'd64277;
            5'd15:   v = 17'd65220;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

// File: src/mbe_pix_if.sv
// Pixel request channel: valid/ready handshake with the pixel coordinate.
// Depends on mbe_pkg for the pixel width.
interface mbe_pix_if;
    logic                           valid;
    logic                           ready;
    logic [mbe_pkg::PIXEL_BITS-1:0] pixel_x;
    logic [mbe_pkg::PIXEL_BITS-1:0] pixel_y;

    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// File: src/mbe_res_if.sv
// Pixel result channel: valid/ready handshake with escape data and color.
// Depends on mbe_pkg for the pixel and iteration widths.
interface mbe_res_if;
    logic                           valid;
    logic                           ready;
    logic [mbe_pkg::PIXEL_BITS-1:0] out_x;
    logic [mbe_pkg::PIXEL_BITS-1:0] out_y;
    logic                           escaped;
    logic [mbe_pkg::ITER_BITS-1:0]  iterations;
    logic [7:0]                     red;
    logic [7:0]                     green;
    logic [7:0]                     blue;

    modport source (output valid, out_x, out_y, escaped, iterations, red, green, blue,
                    input ready);
    modport sink   (input valid, out_x, out_y, escaped, iterations, red, green, blue,
                    output ready);
endinterface

// File: src/mbe_mul.sv
// Iterative 64x64 multiplier built on one 32x32 multiplier, optional sign handling.
// Four partial products, one per cycle; result valid with o_done. Uses no package.
module mbe_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_sgn,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);
    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_neg;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic [127:0] r_prod;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [1:0]   acc_sel;
    logic [127:0] pp_shift;

    always_comb begin
        a_part  = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        b_part  = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        acc_sel = 2'(r_cnt - 3'd1);
        case (acc_sel)
            2'd0:    pp_shift = {64'd0, r_pp};
            2'd3:    pp_shift = {r_pp, 64'd0};
            default: pp_shift = {32'd0, r_pp, 32'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= (i_sgn && i_a[63]) ? 64'd0 - i_a : i_a;
            r_b   <= (i_sgn && i_b[63]) ? 64'd0 - i_b : i_b;
            r_neg <= i_sgn && (i_a[63] ^ i_b[63]);
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) r_pp <= 64'(a_part * b_part);
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) r_acc <= r_acc + pp_shift;
            if (r_cnt == 3'd5) r_prod <= r_neg ? 128'd0 - r_acc : r_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

// File: src/mandelbrot_escape_pixel.sv
// Escape-time pixel engine: maps a pixel to c, iterates z = z^2 + c, colors escapes.
// Steps: map, iteration runs, and for an escape normalize, log, 16-step divide and
// three sine lookups, then hand out. Each iteration takes three 64x64 products in the
// shared unit (load, four passes through its 32x32 multiplier, sign fix, hand back).
// One pixel at a time: ready only while idle. Synchronous active-low reset clears
// control and the configuration registers (max_iterations to 1500, others to 0).
module mandelbrot_escape_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    mbe_pix_if.sink     i_pix,
    mbe_res_if.source   o_res
);
    localparam int F = mbe_pkg::FRAC_BITS;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_MAPX = 14'b00000000000010,
        S_MAPY = 14'b00000000000100,
        S_ZZ   = 14'b00000000001000,
        S_SQA  = 14'b00000000010000,
        S_SQB  = 14'b00000000100000,
        S_NORM = 14'b00000001000000,
        S_LOGM = 14'b00000010000000,
        S_LOGW = 14'b00000100000000,
        S_DIV  = 14'b00001000000000,
        S_VAL  = 14'b00010000000000,
        S_PH   = 14'b00100000000000,
        S_SINW = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [63:0] r_x_start, r_x_step, r_y_start, r_y_step;
    logic [15:0] r_max_iter;

    // shared multiplier command
    logic         r_mul_go,  n_mul_go;
    logic         r_mul_sgn, n_mul_sgn;
    logic [63:0]  r_mul_a,   n_mul_a;
    logic [63:0]  r_mul_b,   n_mul_b;
    logic         mul_done;
    logic [127:0] prod;

    // pixel working state
    logic [mbe_pkg::PIXEL_BITS-1:0] r_px, r_py;
    logic [mbe_pkg::ITER_BITS-1:0]  r_limit, r_iter;
    logic [63:0]  r_cr, r_ci, r_zr, r_zi, r_zrs, r_zis;
    logic [127:0] r_sqa, r_sum;
    logic [6:0]   r_e;
    logic [16:0]  r_base;
    logic [mbe_pkg::LG_W-1:0] r_lg;
    logic [mbe_pkg::LG_W:0]   r_rem;
    logic [15:0]  r_q;
    logic [3:0]   r_dcnt;
    logic [31:0]  r_v;
    logic [1:0]   r_ch;
    logic [1:0]   r_quad;

    // result registers
    logic        r_esc;
    logic [mbe_pkg::ITER_BITS-1:0] r_oiter;
    logic [7:0]  r_red, r_green, r_blue;

    // combinational datapath
    logic [63:0]  zz_shr, nzi, nzr, dz, sum_zr;
    logic [127:0] sq_sum;
    logic         esc_hit, last_iter;
    logic [4:0]   lidx;
    logic [15:0]  lfrac_f, ldiff;
    logic [mbe_pkg::LG_W-1:0] lg_val;
    logic [mbe_pkg::LG_W:0]   rem2;
    logic [32:0]  v_full;
    logic [46:0]  pfold;
    logic [4:0]   sidx;
    logic [16:0]  sbase;
    logic [15:0]  sdiff;
    logic [16:0]  sval;
    logic [17:0]  num;
    logic [25:0]  c26;
    logic [7:0]   cbyte;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (((a ^ r) & (b ^ r)) >> 63 != 64'd0)
            r = a[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        return r;
    endfunction

    mbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_sgn   (r_mul_sgn),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    always_comb begin
        // iteration update: shift the cross product by one less to double it
        zz_shr    = prod[F+62:F-1];
        nzi       = sat_add(zz_shr, r_ci);
        dz        = r_zrs - r_zis;
        nzr       = sat_add(dz, r_cr);
        sum_zr    = nzr;
        sq_sum    = r_sqa + prod;
        esc_hit   = sq_sum > (128'd1 << (2 * F + 2));
        last_iter = ({1'b0, r_iter} + 1'b1) == {1'b0, r_limit};

        // log2 mantissa lookup from the normalized magnitude
        lidx    = {1'b0, r_sum[126:123]};
        lfrac_f = r_sum[122:107];
        ldiff   = 16'(mbe_pkg::log_tab(lidx + 5'd1) - mbe_pkg::log_tab(lidx));
        lg_val  = {7'(r_e - 7'(2 * F)), 16'd0}
                + mbe_pkg::LG_W'(r_base) + mbe_pkg::LG_W'(prod[31:16]);

        rem2   = {r_rem[mbe_pkg::LG_W-1:0], 1'b0};
        v_full = {({1'b0, r_iter} + 17'd1), 16'd0} - {17'd0, r_q};

        // fold the phase into the first quadrant
        pfold = prod[46] ? (47'd1 << 46) - {1'b0, prod[45:0]} : {1'b0, prod[45:0]};
        sidx  = pfold[46:42];
        if (sidx[4]) begin
            sbase = 17'd65536;
            sdiff = 16'd0;
        end else begin
            sbase = mbe_pkg::sine_tab(sidx);
            sdiff = 16'(mbe_pkg::sine_tab(sidx + 5'd1) - mbe_pkg::sine_tab(sidx));
        end

        sval  = r_base + 17'(prod[31:16]);
        num   = r_quad[1] ? 18'd65536 - {1'b0, sval} : 18'd65536 + {1'b0, sval};
        c26   = {num, 8'd0} - {8'd0, num};
        cbyte = (c26[25:17] > 9'd255) ? 8'd255 : c26[24:17];
    end

    // sequencer: next state and multiplier commands
    always_comb begin
        n_state   = r_state;
        n_mul_go  = 1'b0;
        n_mul_sgn = 1'b0;
        n_mul_a   = r_mul_a;
        n_mul_b   = r_mul_b;
        unique case (r_state)
            S_IDLE: begin
                if (i_pix.valid) begin
                    n_mul_go = 1'b1;
                    n_mul_a  = 64'(i_pix.pixel_x);
                    n_mul_b  = r_x_step;
                    n_state  = S_MAPX;
                end
            end
            S_MAPX: begin
                if (mul_done) begin
                    n_mul_go = 1'b1;
                    n_mul_a  = 64'(r_py);
                    n_mul_b  = r_y_step;
                    n_state  = S_MAPY;
                end
            end
            S_MAPY: begin
                if (mul_done) begin
                    if (r_limit == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_mul_go  = 1'b1;
                        n_mul_sgn = 1'b1;
                        n_mul_a   = 64'd0;
                        n_mul_b   = 64'd0;
                        n_state   = S_ZZ;
                    end
                end
            end
            S_ZZ: begin
                if (mul_done) begin
                    n_mul_go  = 1'b1;
                    n_mul_sgn = 1'b1;
                    n_mul_a   = sum_zr;
                    n_mul_b   = sum_zr;
                    n_state   = S_SQA;
                end
            end
            S_SQA: begin
                if (mul_done) begin
                    n_mul_go  = 1'b1;
                    n_mul_sgn = 1'b1;
                    n_mul_a   = r_zi;
                    n_mul_b   = r_zi;
                    n_state   = S_SQB;
                end
            end
            S_SQB: begin
                if (mul_done) begin
                    if (esc_hit) begin
                        n_state = S_NORM;
                    end else if (last_iter) begin
                        n_state = S_OUT;
                    end else begin
                        n_mul_go  = 1'b1;
                        n_mul_sgn = 1'b1;
                        n_mul_a   = r_zr;
                        n_mul_b   = r_zi;
                        n_state   = S_ZZ;
                    end
                end
            end
            S_NORM: begin
                if (r_sum[127]) n_state = S_LOGM;
            end
            S_LOGM: begin
                n_mul_go = 1'b1;
                n_mul_a  = 64'(ldiff);
                n_mul_b  = 64'(lfrac_f);
                n_state  = S_LOGW;
            end
            S_LOGW: begin
                if (mul_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_dcnt == 4'd15) n_state = S_VAL;
            end
            S_VAL: begin
                n_mul_go = 1'b1;
                n_mul_a  = 64'(v_full[31:0]);
                n_mul_b  = 64'(mbe_pkg::turn_k(2'd0));
                n_state  = S_PH;
            end
            S_PH: begin
                if (mul_done) begin
                    n_mul_go = 1'b1;
                    n_mul_a  = 64'(sdiff);
                    n_mul_b  = 64'(pfold[41:26]);
                    n_state  = S_SINW;
                end
            end
            S_SINW: begin
                if (mul_done) begin
                    if (r_ch == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_mul_go = 1'b1;
                        n_mul_a  = 64'(r_v);
                        n_mul_b  = 64'(mbe_pkg::turn_k(r_ch + 2'd1));
                        n_state  = S_PH;
                    end
                end
            end
            S_OUT: begin
                if (o_res.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mul_go   <= 1'b0;
            r_x_start  <= 64'd0;
            r_x_step   <= 64'd0;
            r_y_start  <= 64'd0;
            r_y_step   <= 64'd0;
            r_max_iter <= 16'd1500;
        end else begin
            r_state  <= n_state;
            r_mul_go <= n_mul_go;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mbe_pkg::CFG_X_START:  r_x_start  <= i_cfg_data;
                    mbe_pkg::CFG_X_STEP:   r_x_step   <= i_cfg_data;
                    mbe_pkg::CFG_Y_START:  r_y_start  <= i_cfg_data;
                    mbe_pkg::CFG_Y_STEP:   r_y_step   <= i_cfg_data;
                    mbe_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mul_sgn <= n_mul_sgn;
        r_mul_a   <= n_mul_a;
        r_mul_b   <= n_mul_b;
        case (r_state)
            S_IDLE: begin
                // hold the pixel and the limit for the whole transfer
                r_px    <= i_pix.pixel_x;
                r_py    <= i_pix.pixel_y;
                r_limit <= r_max_iter[mbe_pkg::ITER_BITS-1:0];
            end
            S_MAPX: if (mul_done) r_cr <= r_x_start + prod[63:0];
            S_MAPY: begin
                if (mul_done) begin
                    r_ci    <= r_y_start + prod[63:0];
                    r_zr    <= 64'd0;
                    r_zi    <= 64'd0;
                    r_zrs   <= 64'd0;
                    r_zis   <= 64'd0;
                    r_iter  <= '0;
                    r_esc   <= 1'b0;
                    r_oiter <= r_limit;
                    r_red   <= 8'd0;
                    r_green <= 8'd0;
                    r_blue  <= 8'd0;
                end
            end
            S_ZZ: begin
                if (mul_done) begin
                    r_zr <= nzr;
                    r_zi <= nzi;
                end
            end
            S_SQA: if (mul_done) r_sqa <= prod;
            S_SQB: begin
                if (mul_done) begin
                    r_sum <= sq_sum;
                    r_e   <= 7'd127;
                    r_zrs <= r_sqa[F+63:F];
                    r_zis <= prod[F+63:F];
                    if (esc_hit) begin
                        r_esc   <= 1'b1;
                        r_oiter <= r_iter;
                    end else if (!last_iter) begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
            end
            S_NORM: begin
                // advance the leading one to the top bit
                if (!r_sum[127]) begin
                    r_sum <= {r_sum[126:0], 1'b0};
                    r_e   <= r_e - 7'd1;
                end
            end
            S_LOGM: r_base <= mbe_pkg::log_tab(lidx);
            S_LOGW: begin
                if (mul_done) begin
                    r_lg   <= lg_val;
                    r_rem  <= (mbe_pkg::LG_W + 1)'(mbe_pkg::SMOOTH_K);
                    r_q    <= 16'd0;
                    r_dcnt <= 4'd0;
                end
            end
            S_DIV: begin
                r_dcnt <= r_dcnt + 4'd1;
                if (rem2 >= {1'b0, r_lg}) begin
                    r_rem <= rem2 - {1'b0, r_lg};
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[14:0], 1'b0};
                end
            end
            S_VAL: begin
                r_v  <= v_full[31:0];
                r_ch <= 2'd0;
            end
            S_PH: begin
                if (mul_done) begin
                    r_quad <= prod[47:46];
                    r_base <= sbase;
                end
            end
            S_SINW: begin
                if (mul_done) begin
                    case (r_ch)
                        2'd0:    r_red   <= cbyte;
                        2'd1:    r_green <= cbyte;
                        default: r_blue  <= cbyte;
                    endcase
                    r_ch <= r_ch + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign i_pix.ready      = (r_state == S_IDLE);
    assign o_res.valid      = (r_state == S_OUT);
    assign o_res.out_x      = r_px;
    assign o_res.out_y      = r_py;
    assign o_res.escaped    = r_esc;
    assign o_res.iterations = r_oiter;
    assign o_res.red        = r_red;
    assign o_res.green      = r_green;
    assign o_res.blue       = r_blue;

    // a pixel is never taken while a result is still offered
    a_one_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pix.ready && o_res.valid))
        else $error("input ready while result pending");

    // an interior pixel is black and reports the limit
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.escaped) |->
        (o_res.red == 8'd0 && o_res.green == 8'd0 && o_res.blue == 8'd0 &&
         o_res.iterations == r_limit))
        else $error("interior pixel result wrong");

    // an escape index always lies below the limit
    a_escape_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.escaped) |-> (o_res.iterations < r_limit))
        else $error("escape index out of range");

    // the multiplier finishes only while the sequencer waits on it
    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MAPX || r_state == S_MAPY || r_state == S_ZZ ||
                      r_state == S_SQA || r_state == S_SQB || r_state == S_LOGW ||
                      r_state == S_PH || r_state == S_SINW))
        else $error("multiplier done in wrong state");
endmodule
